// ===== design/lpqd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpqd_pkg
// Shared types and constants for the lidar point qualify/decimate filter.
// ----------------------------------------------------------------------------
package lpqd_pkg;

    // Coordinate width, used by the payload structs below
    localparam int COORD_BITS = 24;

    // Default queue depths
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Configuration reset values
    localparam logic [7:0]  LINE_COUNT_RST = 8'd6;
    localparam logic [7:0]  DECIMATION_RST = 8'd1;
    localparam logic [15:0] BLIND_MM_RST   = 16'd4000;

    // Return number codes (tag bits 5:4)
    localparam logic [1:0] RET_FIRST  = 2'b00;
    localparam logic [1:0] RET_SECOND = 2'b01;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LINE_COUNT = 2'd0,
        CFG_DECIMATION = 2'd1,
        CFG_BLIND_MM   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  line_count;
        logic [7:0]  decimation;
        logic [15:0] blind_mm;
    } cfg_t;

    typedef struct packed {
        logic                         frame_start;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [7:0]                   reflectivity;
        logic [31:0]                  offset_ns;
        logic [7:0]                   scan_line;
        logic [7:0]                   tag_bits;
    } point_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [7:0]                   intensity;
        logic [31:0]                  time_ns;
    } result_t;

    // Sampled point handed from front to back
    typedef struct packed {
        result_t pt;
        logic    differs;
    } sample_t;

endpackage

// ===== design/lpqd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpqd_fifo
// Small register-based queue, first-word fall-through.
// ----------------------------------------------------------------------------
module lpqd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] data_in,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] data_out,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ===== design/lpqd_front.sv =====
// ----------------------------------------------------------------------------
// lpqd_front
// Qualifies each point, runs the decimation counter and tracks the last sampled
// point (cleared by any unsampled point); sampled points go to the middle queue with a "differs" flag.
// ----------------------------------------------------------------------------
module lpqd_front
    import lpqd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    push,
    input  point_t  point,
    output logic    full,
    input  logic    mid_full,
    output logic    mid_push,
    output sample_t mid_item
);

    logic [7:0]                   cnt_reg, cnt_next;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_BITS-1:0] prev_y_reg, prev_y_next;
    logic signed [COORD_BITS-1:0] prev_z_reg, prev_z_next;
    logic                         accept;
    logic                         pt_valid;
    logic [1:0]                   ret;
    logic [8:0]                   cnt_inc;
    logic                         sample_hit;

    assign full   = mid_full;
    assign accept = push && !mid_full;

    // Classification
    assign ret        = point.tag_bits[5:4];
    assign pt_valid   = (point.scan_line < cfg.line_count) &&
                        ((ret == RET_FIRST) || (ret == RET_SECOND));
    assign cnt_inc    = {1'b0, cnt_reg} + 9'd1;
    assign sample_hit = !point.frame_start && pt_valid &&
                        !(cnt_inc < {1'b0, cfg.decimation});

    // State update on each accepted point
    always_comb
    begin
        cnt_next    = cnt_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        prev_z_next = prev_z_reg;
        if (accept)
        begin
            if (sample_hit)
            begin
                cnt_next    = '0;
                prev_x_next = point.pos_x;
                prev_y_next = point.pos_y;
                prev_z_next = point.pos_z;
            end
            else
            begin
                prev_x_next = '0;
                prev_y_next = '0;
                prev_z_next = '0;
                if (point.frame_start)
                begin
                    cnt_next = '0;
                end
                else if (pt_valid)
                begin
                    cnt_next = cnt_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            prev_z_reg <= prev_z_next;
        end
    end

    // Sampled point to the middle queue
    assign mid_push             = accept && sample_hit;
    assign mid_item.pt.out_x     = point.pos_x;
    assign mid_item.pt.out_y     = point.pos_y;
    assign mid_item.pt.out_z     = point.pos_z;
    assign mid_item.pt.intensity = point.reflectivity;
    assign mid_item.pt.time_ns   = point.offset_ns;
    assign mid_item.differs      = (point.pos_x != prev_x_reg) ||
                                   (point.pos_y != prev_y_reg) ||
                                   (point.pos_z != prev_z_reg);

endmodule

// ===== design/lpqd_back.sv =====
// ----------------------------------------------------------------------------
// lpqd_back
// Blind-zone test: squares the coordinate magnitudes in one registered stage,
// then sums and compares against the squared radius and pushes kept points.
// ----------------------------------------------------------------------------
module lpqd_back
    import lpqd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [15:0]   blind_mm,
    input  logic          mid_empty,
    input  sample_t       mid_item,
    output logic          mid_pop,
    input  logic          out_full,
    output logic          out_push,
    output result_t       out_item
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 2;

    logic [COORD_BITS-1:0] mag_x, mag_y, mag_z;
    logic [SQ_W-1:0]       sq_x_next, sq_y_next, sq_z_next;
    logic [SQ_W-1:0]       sq_x_reg, sq_y_reg, sq_z_reg;
    logic [31:0]           blind2_reg, blind2_next;
    logic                  s1_valid_reg, s1_valid_next;
    result_t               s1_pt_reg;
    logic                  s1_differs_reg;
    logic                  s1_advance;
    logic [SUM_W-1:0]      dist2;
    logic                  keep;

    function automatic logic [COORD_BITS-1:0] mag_of(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] r;
        r = v[COORD_BITS-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    // Squared radius, follows the register
    assign blind2_next = 32'(blind_mm) * 32'(blind_mm);

    // Stage 1: magnitudes and squares
    assign mag_x     = mag_of(mid_item.pt.out_x);
    assign mag_y     = mag_of(mid_item.pt.out_y);
    assign mag_z     = mag_of(mid_item.pt.out_z);
    assign sq_x_next = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y_next = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign sq_z_next = SQ_W'(mag_z) * SQ_W'(mag_z);

    assign s1_advance    = !s1_valid_reg || !out_full;
    assign mid_pop       = !mid_empty && s1_advance;
    assign s1_valid_next = mid_pop ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            blind2_reg   <= 32'(BLIND_MM_RST) * 32'(BLIND_MM_RST);
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            blind2_reg   <= blind2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            s1_pt_reg      <= mid_item.pt;
            s1_differs_reg <= mid_item.differs;
            sq_x_reg       <= sq_x_next;
            sq_y_reg       <= sq_y_next;
            sq_z_reg       <= sq_z_next;
        end
    end

    // Stage 2: sum, compare, push kept point
    assign dist2    = SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg) + SUM_W'(sq_z_reg);
    assign keep     = s1_differs_reg && (dist2 > SUM_W'(blind2_reg));
    assign out_push = s1_valid_reg && !out_full && keep;
    assign out_item = s1_pt_reg;

endmodule

// ===== design/lidar_point_qualify_decimate_filter_core.sv =====
// ----------------------------------------------------------------------------
// lidar_point_qualify_decimate_filter_core
// Lidar point qualifier, decimator and blind-zone filter.
//
//   Channel  Handshake          Payload     Notes
//   point    push / full        point_t     one point per beat
//   result   empty / pop        result_t    oldest kept point while !empty
//   config   cfg_valid/ready    idx + data  line_count, decimation, blind_mm
//
// One point is accepted per cycle unless the front stalls; a kept point passes
// the middle queue, stage-1 register and result queue. The front stalls only
// when the middle queue is full; the square/compare stage stalls only when the
// result queue is full. Reset puts the config registers at their defaults and
// empties both queues. No clearing pass after reset.
// ----------------------------------------------------------------------------
module lidar_point_qualify_decimate_filter_core
    import lpqd_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  point_t      point,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    mid_push, mid_full, mid_pop, mid_empty;
    sample_t mid_in, mid_out;
    logic    out_push, out_full;
    result_t out_in;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINE_COUNT: cfg_next.line_count = cfg_data[7:0];
                CFG_DECIMATION: cfg_next.decimation = cfg_data[7:0];
                CFG_BLIND_MM:   cfg_next.blind_mm   = cfg_data;
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_count <= LINE_COUNT_RST;
            cfg_reg.decimation <= DECIMATION_RST;
            cfg_reg.blind_mm   <= BLIND_MM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: qualify and decimate
    lpqd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .point    (point),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_in)
    );

    // Middle queue
    lpqd_fifo #(
        .WIDTH ($bits(sample_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (mid_push),
        .data_in  (mid_in),
        .full     (mid_full),
        .pop      (mid_pop),
        .data_out (mid_out),
        .empty    (mid_empty)
    );

    // Back: blind-zone test
    lpqd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .blind_mm  (cfg_reg.blind_mm),
        .mid_empty (mid_empty),
        .mid_item  (mid_out),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_item  (out_in)
    );

    // Result queue
    lpqd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .data_in  (out_in),
        .full     (out_full),
        .pop      (pop),
        .data_out (result),
        .empty    (empty)
    );

    // Checks
    ap_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> !mid_full)
        else $error("middle queue written while full");

    ap_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result queue written while full");

    ap_mid_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty)
        else $error("middle queue read while empty");

    ap_sample_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        mid_push |-> (push && !full && !point.frame_start))
        else $error("sample pushed without an accepted non-frame-start point");

endmodule

// ===== tb/tb_lidar_point_qualify_decimate_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_lidar_point_qualify_decimate_filter_core
// Self-checking bench for the lidar point qualify/decimate filter. Points go in
// through the push/full queue port. Kept points are popped and compared field
// by field against an in-bench prediction of the qualify, decimate and
// blind-zone rules. A directed pass covers the corner cases. Random phases then
// run under several register settings, mostly with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_lidar_point_qualify_decimate_filter_core;
    import lpqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Unmapped register index, writes to it must have no effect
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_POINTS = 135;

    logic        clk;
    logic        rst_n;
    logic        push;
    point_t      point;
    logic        full;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor copy of registers and state
    logic [7:0]  cfg_lines = LINE_COUNT_RST;
    logic [7:0]  cfg_decim = DECIMATION_RST;
    logic [15:0] cfg_blind = BLIND_MM_RST;
    logic [7:0]  run_count = '0;
    logic signed [COORD_BITS-1:0] last_x = '0;
    logic signed [COORD_BITS-1:0] last_y = '0;
    logic signed [COORD_BITS-1:0] last_z = '0;

    result_t kept_points[$];
    point_t  prev_sent = '0;
    bit      calm = 1'b0;
    int      mismatches = 0;

    lidar_point_qualify_decimate_filter_core dut (
        .clk,
        .rst_n,
        .push,
        .point,
        .full,
        .empty,
        .pop,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Squared magnitude of one axis, exact
    function automatic longint unsigned axis_sq(input logic signed [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] m;
        longint unsigned m64;
        m = v[COORD_BITS-1] ? (~v + 1'b1) : v;
        m64 = m;
        return m64 * m64;
    endfunction

    // Qualify/decimate/blind-zone prediction; returns 1 when the point is kept
    function automatic bit qualify_point(input point_t p, output result_t r);
        int unsigned     cnt;
        bit              differs;
        longint unsigned range2;
        longint unsigned blind2;
        r = '0;
        // Frame start: dropped, restarts the count and clears the last point
        if (p.frame_start)
        begin
            run_count = '0;
            last_x = '0;
            last_y = '0;
            last_z = '0;
            return 1'b0;
        end
        // Rejected point
        if (!(p.scan_line < cfg_lines &&
              (p.tag_bits[5:4] == RET_FIRST || p.tag_bits[5:4] == RET_SECOND)))
        begin
            last_x = '0;
            last_y = '0;
            last_z = '0;
            return 1'b0;
        end
        // Valid but not sampled
        cnt = run_count + 1;
        if (cnt < cfg_decim)
        begin
            run_count = cnt[7:0];
            last_x = '0;
            last_y = '0;
            last_z = '0;
            return 1'b0;
        end
        run_count = '0;
        // Sampled: becomes the last point whether kept or not
        differs = (p.pos_x != last_x) || (p.pos_y != last_y) || (p.pos_z != last_z);
        last_x = p.pos_x;
        last_y = p.pos_y;
        last_z = p.pos_z;
        range2 = axis_sq(p.pos_x) + axis_sq(p.pos_y) + axis_sq(p.pos_z);
        blind2 = longint'(cfg_blind) * longint'(cfg_blind);
        if (!(differs && range2 > blind2))
            return 1'b0;
        r.out_x = p.pos_x;
        r.out_y = p.pos_y;
        r.out_z = p.pos_z;
        r.intensity = p.reflectivity;
        r.time_ns = p.offset_ns;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic point_t make_point(input bit fs, input int x, input int y, input int z,
                                          input logic [7:0] line, input logic [7:0] tag);
        point_t p;
        p.frame_start = fs;
        p.pos_x = x[COORD_BITS-1:0];
        p.pos_y = y[COORD_BITS-1:0];
        p.pos_z = z[COORD_BITS-1:0];
        p.reflectivity = $urandom;
        p.offset_ns = $urandom;
        p.scan_line = line;
        p.tag_bits = tag;
        return p;
    endfunction

    // Random point, biased toward valid lines/tags and the blind radius
    function automatic point_t random_point();
        int kind;
        int pick;
        int b;
        int c[3];
        logic [7:0] line;
        logic [7:0] tag;
        bit fs;
        b = cfg_blind;
        kind = $urandom_range(0, 99);
        foreach (c[i])
            c[i] = 0;
        if (kind < 30)
        begin
            foreach (c[i])
                c[i] = $urandom;
        end
        else if (kind < 55)
        begin
            // On, just inside or just outside the radius along one axis
            foreach (c[i])
                c[i] = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 6)) - 3;
            pick = $urandom_range(0, 2);
            c[pick] = b + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1) == 1)
                c[pick] = -c[pick];
        end
        else if (kind < 70)
        begin
            c[0] = prev_sent.pos_x;
            c[1] = prev_sent.pos_y;
            c[2] = prev_sent.pos_z;
        end
        else if (kind < 85)
        begin
            foreach (c[i])
                c[i] = int'($urandom_range(0, b)) - b / 2;
        end
        else if (kind < 95)
        begin
            foreach (c[i])
            begin
                case ($urandom_range(0, 4))
                    0:       c[i] = -8388608;
                    1:       c[i] = 8388607;
                    2:       c[i] = -1;
                    3:       c[i] = 1;
                    default: c[i] = 0;
                endcase
            end
        end
        fs = ($urandom_range(0, 31) == 0);
        if (cfg_lines != 0 && $urandom_range(0, 99) < 85)
            line = $urandom_range(0, cfg_lines - 1);
        else
            line = $urandom;
        tag = $urandom;
        if ($urandom_range(0, 99) < 85)
            tag[5] = 1'b0;
        return make_point(fs, c[0], c[1], c[2], line, tag);
    endfunction

    // Send one point beat; push stays high for a back-to-back follower
    task automatic send_point(input point_t p);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        prev_sent = p;
        if (qualify_point(p, r))
            kept_points = {kept_points, r};
    endtask

    // Stop pushing, wait until all kept points are out and the pipe is quiet
    task automatic settle_block();
        push <= 1'b0;
        while (kept_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register beat; cfg_valid is left high for a following beat
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LINE_COUNT: cfg_lines = data[7:0];
            CFG_DECIMATION: cfg_decim = data[7:0];
            CFG_BLIND_MM:   cfg_blind = data;
            default: ;
        endcase
    endtask

    // Write all three registers; junk in the unused upper byte of 8-bit ones
    task automatic program_config(input cfg_t c);
        write_reg(CFG_LINE_COUNT, {8'($urandom), c.line_count});
        write_reg(CFG_DECIMATION, {8'($urandom), c.decimation});
        write_reg(CFG_BLIND_MM, c.blind_mm);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Reset settings: frame start, radius edge, repeats, tags and lines, extremes
    task automatic test_defaults();
        send_point(make_point(1, -8388608, 8388607, -1, 8'd0, 8'h00));
        send_point(make_point(0, 4000, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, 4001, 0, 0, 8'd1, 8'h10));
        send_point(make_point(0, 4001, 0, 0, 8'd2, 8'h10));
        send_point(make_point(0, -8388608, -8388608, -8388608, 8'd5, 8'hCF));
        send_point(make_point(0, 8388607, 8388607, 8388607, 8'd0, 8'h20));
        send_point(make_point(0, 8388607, 8388607, 8388607, 8'd0, 8'hFF));
        send_point(make_point(0, 8388607, 8388607, 8388607, 8'd6, 8'h00));
        send_point(make_point(0, 8388607, 8388607, 8388607, 8'd255, 8'h00));
        send_point(make_point(0, 8388607, 8388607, 8388607, 8'd0, 8'h00));
        send_point(make_point(0, 0, 0, 0, 8'd3, 8'h00));
        send_point(make_point(0, 0, 0, -4001, 8'd4, 8'h10));
    endtask

    // Every third valid point; rejected points do not count, frame start restarts
    task automatic test_decimation();
        settle_block();
        program_config('{8'd255, 8'd3, 16'd0});
        send_point(make_point(1, 5, 5, 5, 8'd0, 8'h00));
        send_point(make_point(0, 5, 5, 5, 8'd254, 8'h10));
        send_point(make_point(0, 5, 5, 5, 8'd0, 8'h30));
        send_point(make_point(0, 5, 5, 5, 8'd0, 8'h00));
        send_point(make_point(0, 5, 5, 5, 8'd0, 8'h00));
        send_point(make_point(1, 1, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, 1, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, 1, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, 1, 0, 0, 8'd0, 8'h00));
    endtask

    // Line count zero, decimation zero, widest blind radius, unmapped index
    task automatic test_zero_settings();
        settle_block();
        write_reg(CFG_SPARE, 16'hFFFF);
        program_config('{8'd0, 8'd0, 16'hFFFF});
        send_point(make_point(0, 8388607, 0, 0, 8'd0, 8'h00));
        settle_block();
        program_config('{8'd1, 8'd0, 16'hFFFF});
        send_point(make_point(0, 65535, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, -65536, 0, 0, 8'd0, 8'h00));
        send_point(make_point(0, 0, 65536, 0, 8'd1, 8'h00));
        send_point(make_point(0, -65536, 0, 0, 8'd0, 8'h10));
    endtask

    // Random phases over fixed extreme and random settings
    task automatic test_random();
        cfg_t setting;
        int   phase;
        int   n;
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: setting = '{8'd6, 8'd1, 16'd4000};
                1: setting = '{8'd255, 8'd1, 16'd0};
                2: setting = '{8'd1, 8'd2, 16'hFFFF};
                3: setting = '{8'd255, 8'd255, 16'd100};
                4: setting = '{8'd128, 8'd4, 16'd4000};
                default:
                begin
                    setting.line_count = $urandom_range(1, 255);
                    setting.decimation = $urandom_range(1, 5);
                    setting.blind_mm = $urandom_range(0, 65535);
                end
            endcase
            settle_block();
            calm = (phase == 1) || (phase == 5);
            program_config(setting);
            for (n = 0; n < PHASE_POINTS; n++)
                send_point(random_point());
        end
        calm = 1'b0;
    endtask

    // Result side: random pop stalls, each popped beat checked in order
    initial
    begin : result_check
        result_t want;
        int      hold;
        hold = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (pop && !empty)
                begin
                    if (kept_points.size() == 0)
                    begin
                        mismatches++;
                        $error("result beat with no kept point pending: x=%0d y=%0d z=%0d",
                               result.out_x, result.out_y, result.out_z);
                    end
                    else
                    begin
                        want = kept_points.pop_front();
                        check_field("out_x", want.out_x, result.out_x);
                        check_field("out_y", want.out_y, result.out_y);
                        check_field("out_z", want.out_z, result.out_z);
                        check_field("intensity", want.intensity, result.intensity);
                        check_field("time_ns", want.time_ns, result.time_ns);
                    end
                end
                if (hold > 0)
                begin
                    pop <= 1'b0;
                    hold--;
                end
                else
                begin
                    pop <= 1'b1;
                    hold = pick_gap();
                end
            end
        end
    end

    // Sequence
    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        point <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LINE_COUNT;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_decimation();
        test_zero_settings();
        test_random();
        settle_block();
        if (mismatches == 0 && kept_points.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
